// ===== hw/rtl/zpf_pkg.sv =====
// Shared types, constants and helpers for the zoom/pan/flip coordinate mapper.
// No dependencies; every other file refers to this package by scoped names.
package zpf_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ACT_W          = 2;
    localparam int ZOOM_W         = 6;
    localparam int ZMAG_W         = 6;
    localparam int SPAN_W         = 13;
    localparam int PIX_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int DIV_STEP       = 4;
    localparam int DIFF_W         = 15;
    localparam int REM_W          = 7;
    localparam int SCREEN_MAX     = 8191;

    typedef enum logic [ACT_W-1:0] {
        ACT_TO_IMAGE = 2'd0,
        ACT_TO_VIEW  = 2'd1,
        ACT_LOWER    = 2'd2,
        ACT_UPPER    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM         = 3'd0,
        REG_CENTER_X     = 3'd1,
        REG_CENTER_Y     = 3'd2,
        REG_VIEW_WIDTH   = 3'd3,
        REG_VIEW_HEIGHT  = 3'd4,
        REG_FLIP_MODE    = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } t_reg_index;

    // Decoded zoom: magnitude (1..32), shrink flag, and "magnify by more than one".
    typedef struct packed {
        logic [ZMAG_W-1:0] zmag;
        logic              zneg;
        logic              zgt1;
    } t_zoom_ctl;

    function automatic t_zoom_ctl decode_zoom(logic signed [ZOOM_W-1:0] z);
        t_zoom_ctl c;
        c.zneg = z[ZOOM_W-1];
        c.zgt1 = !z[ZOOM_W-1] && (z > 6'sd1);
        if (c.zneg) begin
            c.zmag = ZMAG_W'(-z);
        end else if (z == 6'sd0) begin
            c.zmag = ZMAG_W'(1);
        end else begin
            c.zmag = ZMAG_W'(z);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/zpf_if.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on zpf_pkg for field widths.
interface zpf_item_if #(parameter int COORD_BITS = zpf_pkg::COORD_BITS_DEF) ();
    logic                              valid;
    logic                              ready;
    logic [zpf_pkg::ACT_W-1:0]         action;
    logic signed [COORD_BITS-1:0]      coord_x;
    logic signed [COORD_BITS-1:0]      coord_y;
    logic [zpf_pkg::SPAN_W-1:0]        start_x;
    logic [zpf_pkg::SPAN_W-1:0]        start_y;

    modport source (output valid, action, coord_x, coord_y, start_x, start_y, input ready);
    modport sink   (input valid, action, coord_x, coord_y, start_x, start_y, output ready);
endinterface

interface zpf_result_if #(parameter int COORD_BITS = zpf_pkg::COORD_BITS_DEF) ();
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      result_x;
    logic signed [COORD_BITS-1:0]      result_y;
    logic [zpf_pkg::PIX_W-1:0]         image_x;
    logic [zpf_pkg::PIX_W-1:0]         image_y;
    logic [zpf_pkg::SPAN_W-1:0]        screen_x;
    logic [zpf_pkg::SPAN_W-1:0]        screen_y;

    modport source (output valid, result_x, result_y, image_x, image_y, screen_x, screen_y,
                    input ready);
    modport sink   (input valid, result_x, result_y, image_x, image_y, screen_x, screen_y,
                    output ready);
endinterface

// ===== hw/rtl/zpf_front.sv =====
// Front end: takes request transfers, classifies the action and forms the first
// scale operand per axis. Depends on zpf_pkg and zpf_item_if.
module zpf_front #(
    parameter int COORD_BITS = zpf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = zpf_pkg::FRAC_BITS_DEF,
    parameter int WIDE_W     = 41,
    parameter int ENTRY_W    = 112
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    zpf_item_if.sink                         i_item,
    input  zpf_pkg::t_zoom_ctl               i_zoom_ctl,
    input  logic signed [COORD_BITS-1:0]     i_center_x,
    input  logic signed [COORD_BITS-1:0]     i_center_y,
    input  logic [zpf_pkg::SPAN_W-1:0]       i_view_width,
    input  logic [zpf_pkg::SPAN_W-1:0]       i_view_height,
    input  logic [1:0]                       i_flip,
    output logic                             o_push_valid,
    input  logic                             i_push_ready,
    output logic [ENTRY_W-1:0]               o_push_data
);

    function automatic logic signed [WIDE_W-1:0] first_operand(
        zpf_pkg::t_action             act,
        logic signed [COORD_BITS-1:0] c,
        logic signed [COORD_BITS-1:0] ctr,
        logic [zpf_pkg::SPAN_W-1:0]   span,
        logic                         flip
    );
        logic signed [WIDE_W-1:0] h;
        logic signed [WIDE_W-1:0] cw;
        logic signed [WIDE_W-1:0] ctrw;
        logic signed [WIDE_W-1:0] sw;
        logic signed [WIDE_W-1:0] d;
        h    = $signed(WIDE_W'(span >> 1) << FRAC_BITS);
        sw   = $signed(WIDE_W'(span) << FRAC_BITS);
        cw   = WIDE_W'(c);
        ctrw = WIDE_W'(ctr);
        case (act)
            zpf_pkg::ACT_TO_IMAGE: d = cw - h;
            zpf_pkg::ACT_TO_VIEW:  d = flip ? (ctrw - cw) : (cw - ctrw);
            zpf_pkg::ACT_LOWER:    d = -h;
            zpf_pkg::ACT_UPPER:    d = sw - h;
            default:               d = '0;
        endcase
        return d;
    endfunction

    logic                     r_valid;
    logic [ENTRY_W-1:0]       r_entry;
    logic [ENTRY_W-1:0]       n_entry;
    logic                     front_ready;
    zpf_pkg::t_action         act;
    logic                     mul;

    assign act         = zpf_pkg::t_action'(i_item.action);
    // view mapping multiplies when magnifying, image mapping when shrinking
    assign mul         = (act == zpf_pkg::ACT_TO_VIEW) ? !i_zoom_ctl.zneg : i_zoom_ctl.zneg;
    assign front_ready = !r_valid || i_push_ready;
    assign i_item.ready = front_ready;

    assign n_entry = {i_item.action, i_item.start_x, i_item.start_y, mul, mul,
                      first_operand(act, i_item.coord_x, i_center_x, i_view_width, i_flip[0]),
                      first_operand(act, i_item.coord_y, i_center_y, i_view_height, i_flip[1])};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (front_ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_ready && i_item.valid) begin
            r_entry <= n_entry;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_entry;

endmodule

// ===== hw/rtl/zpf_queue.sv =====
// Short register queue between front and back so each side stalls on its own.
// Depends on zpf_pkg for the depth.
module zpf_queue #(
    parameter int DATA_W = 112
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int DEPTH = zpf_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]     r_wptr;
    logic [AW-1:0]     r_rptr;
    logic [AW:0]       r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // depth is a power of two: pointers wrap naturally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/zpf_scale.sv =====
// Pipelined scale unit: multiply by the zoom magnitude or divide by it, truncating
// toward zero, with remainder. Four quotient bits per stage. Depends on zpf_pkg.
module zpf_scale #(
    parameter int W     = 41,
    parameter int TAG_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [W-1:0]            i_d,
    input  logic                           i_mul,
    input  logic [zpf_pkg::ZMAG_W-1:0]     i_zmag,
    input  logic [TAG_W-1:0]               i_tag,
    output logic                           o_valid,
    output logic signed [W-1:0]            o_q,
    output logic signed [zpf_pkg::REM_W-1:0] o_rem,
    output logic [TAG_W-1:0]               o_tag
);

    localparam int STEP = zpf_pkg::DIV_STEP;
    localparam int NSTG = (W + STEP - 1) / STEP;
    localparam int ZW   = zpf_pkg::ZMAG_W;

    logic                r_valid [0:NSTG];
    logic [W-1:0]        r_num   [0:NSTG];
    logic [ZW-1:0]       r_rem   [0:NSTG];
    logic                r_sign  [0:NSTG];
    logic                r_mul   [0:NSTG];
    logic [ZW-1:0]       r_zmag  [0:NSTG];
    logic signed [W-1:0] r_prod  [0:NSTG];
    logic [TAG_W-1:0]    r_tag   [0:NSTG];

    logic signed [W+ZW:0] prod_full;
    logic [W-1:0]         mag;

    assign prod_full = i_d * $signed({1'b0, i_zmag});
    assign mag       = i_d[W-1] ? (~i_d + 1'b1) : i_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= mag;
            r_rem[0]  <= '0;
            r_sign[0] <= i_d[W-1];
            r_mul[0]  <= i_mul;
            r_zmag[0] <= i_zmag;
            r_prod[0] <= prod_full[W-1:0];
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic [W-1:0]  n_num;
        logic [ZW-1:0] n_rem;

        // restoring division, dividend bits shift out the top, quotient bits in
        always_comb begin
            logic [ZW:0] t;
            n_num = r_num[k];
            n_rem = r_rem[k];
            t     = '0;
            for (int j = 0; j < STEP; j++) begin
                if (k * STEP + j < W) begin
                    t     = {n_rem, n_num[W-1]};
                    n_num = {n_num[W-2:0], 1'b0};
                    if (t >= {1'b0, r_zmag[k]}) begin
                        t        = t - {1'b0, r_zmag[k]};
                        n_num[0] = 1'b1;
                    end
                    n_rem = t[ZW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1]  <= n_num;
                r_rem[k+1]  <= n_rem;
                r_sign[k+1] <= r_sign[k];
                r_mul[k+1]  <= r_mul[k];
                r_zmag[k+1] <= r_zmag[k];
                r_prod[k+1] <= r_prod[k];
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_valid = r_valid[NSTG];
    assign o_tag   = r_tag[NSTG];
    assign o_q     = r_mul[NSTG] ? r_prod[NSTG]
                   : $signed(r_sign[NSTG] ? (~r_num[NSTG] + 1'b1) : r_num[NSTG]);
    assign o_rem   = $signed(r_sign[NSTG] ? (~{1'b0, r_rem[NSTG]} + 1'b1)
                                          : {1'b0, r_rem[NSTG]});

endmodule

// ===== hw/rtl/zpf_axis.sv =====
// Back end for one axis: image/view mapping, pixel rounding and clamping, view
// position and end trimming. Depends on zpf_pkg and zpf_scale.
module zpf_axis #(
    parameter int COORD_BITS = zpf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = zpf_pkg::FRAC_BITS_DEF,
    parameter int WIDE_W     = 41
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  zpf_pkg::t_action               i_action,
    input  logic [zpf_pkg::SPAN_W-1:0]     i_start,
    input  logic signed [WIDE_W-1:0]       i_d1,
    input  logic                           i_mul,
    input  zpf_pkg::t_zoom_ctl             i_zoom_ctl,
    input  logic signed [COORD_BITS-1:0]   i_center,
    input  logic [zpf_pkg::SPAN_W-1:0]     i_span,
    input  logic                           i_flip,
    input  logic [zpf_pkg::PIX_W-1:0]      i_limit,
    output logic                           o_valid,
    output logic signed [COORD_BITS-1:0]   o_result,
    output logic [zpf_pkg::PIX_W-1:0]      o_image,
    output logic [zpf_pkg::SPAN_W-1:0]     o_screen
);

    localparam int W   = WIDE_W;
    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SW  = zpf_pkg::SPAN_W;
    localparam int PW  = zpf_pkg::PIX_W;
    localparam int AW  = zpf_pkg::ACT_W;
    localparam int DW  = zpf_pkg::DIFF_W;
    localparam int RW  = zpf_pkg::REM_W;
    localparam int T1W = AW + SW;
    localparam int T2W = AW + SW + C + PW;
    localparam int T3W = AW + C + PW + SW;

    localparam logic signed [W-1:0] CMAX  = $signed({{(W-C+1){1'b0}}, {(C-1){1'b1}}});
    localparam logic signed [W-1:0] CMIN  = ~CMAX;
    localparam logic [W-1:0]        FMASK = (W'(1) << F) - W'(1);
    localparam logic signed [W-1:0] HALF  = $signed((W'(1) << F) >> 1);
    localparam logic signed [DW-1:0] SMAX = DW'(zpf_pkg::SCREEN_MAX);

    logic signed [W-1:0] h;
    logic signed [W-1:0] ctrw;

    assign h    = $signed(W'(i_span >> 1) << F);
    assign ctrw = W'(i_center);

    // ---- image/view mapping ----
    logic                s1_valid;
    logic signed [W-1:0] q1;
    logic [T1W-1:0]      s1_tag;

    zpf_scale #(.W(W), .TAG_W(T1W)) u_scale1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_d     (i_d1),
        .i_mul   (i_mul),
        .i_zmag  (i_zoom_ctl.zmag),
        .i_tag   ({i_action, i_start}),
        .o_valid (s1_valid),
        .o_q     (q1),
        .o_rem   (),
        .o_tag   (s1_tag)
    );

    logic [AW-1:0]       s1_act;
    logic [SW-1:0]       s1_start;
    logic signed [W-1:0] p;
    logic signed [W-1:0] pre;
    logic signed [W-1:0] pre_sat;
    logic                up;
    logic [W-1:0]        ipix;
    logic [PW-1:0]       n_ix;
    logic signed [W-1:0] ixw;
    logic signed [W-1:0] n_d2;

    assign {s1_act, s1_start} = s1_tag;
    assign p   = i_flip ? (ctrw - q1) : (ctrw + q1);
    assign pre = (s1_act == zpf_pkg::ACT_TO_VIEW) ? (q1 + h) : p;
    // lower bound rounds away from the view origin, upper bound toward it
    assign up  = (s1_act == zpf_pkg::ACT_LOWER) ? !i_flip : i_flip;

    always_comb begin
        if (pre > CMAX) begin
            pre_sat = CMAX;
        end else if (pre < CMIN) begin
            pre_sat = CMIN;
        end else begin
            pre_sat = pre;
        end
    end

    always_comb begin
        ipix = W'(p >>> F);
        if (up && ((p & FMASK) != '0)) begin
            ipix = ipix + 1'b1;
        end
        if (p[W-1] || (p == '0)) begin
            n_ix = '0;
        end else if (ipix > W'(i_limit)) begin
            n_ix = i_limit;
        end else begin
            n_ix = ipix[PW-1:0];
        end
    end

    assign ixw  = $signed(W'(n_ix) << F);
    assign n_d2 = i_flip ? (ctrw - ixw) : (ixw - ctrw);

    logic                r_s2_valid;
    logic [AW-1:0]       r_s2_act;
    logic [SW-1:0]       r_s2_start;
    logic [C-1:0]        r_s2_result;
    logic [PW-1:0]       r_s2_ix;
    logic signed [W-1:0] r_s2_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_act    <= s1_act;
            r_s2_start  <= s1_start;
            r_s2_result <= pre_sat[C-1:0];
            r_s2_ix     <= n_ix;
            r_s2_d2     <= n_d2;
        end
    end

    // ---- view position of the chosen pixel ----
    logic                s3_valid;
    logic signed [W-1:0] q2;
    logic [T2W-1:0]      s3_tag;

    zpf_scale #(.W(W), .TAG_W(T2W)) u_scale2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_s2_valid),
        .i_d     (r_s2_d2),
        .i_mul   (!i_zoom_ctl.zneg),
        .i_zmag  (i_zoom_ctl.zmag),
        .i_tag   ({r_s2_act, r_s2_start, r_s2_result, r_s2_ix}),
        .o_valid (s3_valid),
        .o_q     (q2),
        .o_rem   (),
        .o_tag   (s3_tag)
    );

    logic [AW-1:0]       s3_act;
    logic [SW-1:0]       s3_start;
    logic [C-1:0]        s3_result;
    logic [PW-1:0]       s3_ix;
    logic signed [W-1:0] v;
    logic [W-1:0]        vs;
    logic [SW-1:0]       n_s;
    logic signed [DW-1:0] n_diff;

    assign {s3_act, s3_start, s3_result, s3_ix} = s3_tag;
    assign v  = q2 + h + HALF;
    assign vs = W'(v >>> F);

    always_comb begin
        if (v[W-1] || (v == '0)) begin
            n_s = '0;
        end else if (vs > W'(i_span)) begin
            n_s = i_span;
        end else begin
            n_s = vs[SW-1:0];
        end
    end

    assign n_diff = $signed(DW'(n_s)) - $signed(DW'(s3_start));

    logic                 r_s4_valid;
    logic [AW-1:0]        r_s4_act;
    logic [C-1:0]         r_s4_result;
    logic [PW-1:0]        r_s4_ix;
    logic [SW-1:0]        r_s4_s;
    logic signed [DW-1:0] r_s4_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_act    <= s3_act;
            r_s4_result <= s3_result;
            r_s4_ix     <= s3_ix;
            r_s4_s      <= n_s;
            r_s4_diff   <= n_diff;
        end
    end

    // ---- trim the end to whole zoomed pixels ----
    logic                 s5_valid;
    logic signed [RW-1:0] rem;
    logic [T3W-1:0]       s5_tag;

    zpf_scale #(.W(DW), .TAG_W(T3W)) u_scale3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_s4_valid),
        .i_d     (r_s4_diff),
        .i_mul   (1'b0),
        .i_zmag  (i_zoom_ctl.zmag),
        .i_tag   ({r_s4_act, r_s4_result, r_s4_ix, r_s4_s}),
        .o_valid (s5_valid),
        .o_q     (),
        .o_rem   (rem),
        .o_tag   (s5_tag)
    );

    logic [AW-1:0]        s5_act;
    logic [C-1:0]         s5_result;
    logic [PW-1:0]        s5_ix;
    logic [SW-1:0]        s5_s;
    logic signed [DW-1:0] e;
    logic [SW-1:0]        e_clamp;

    assign {s5_act, s5_result, s5_ix, s5_s} = s5_tag;
    assign e = (s5_act == zpf_pkg::ACT_UPPER && i_zoom_ctl.zgt1)
             ? ($signed(DW'(s5_s)) - DW'(rem)) : $signed(DW'(s5_s));

    always_comb begin
        if (e < 0) begin
            e_clamp = '0;
        end else if (e > SMAX) begin
            e_clamp = SW'(zpf_pkg::SCREEN_MAX);
        end else begin
            e_clamp = e[SW-1:0];
        end
    end

    assign o_valid  = s5_valid;
    assign o_result = (s5_act == zpf_pkg::ACT_TO_IMAGE || s5_act == zpf_pkg::ACT_TO_VIEW)
                    ? $signed(s5_result) : '0;
    assign o_image  = (s5_act == zpf_pkg::ACT_LOWER) ? s5_ix : '0;
    assign o_screen = (s5_act == zpf_pkg::ACT_LOWER || s5_act == zpf_pkg::ACT_UPPER)
                    ? e_clamp : '0;

endmodule

// ===== hw/rtl/zoom_pan_flip_coordinate_mapper_unit.sv =====
// Zoom/pan/flip coordinate mapper, top level: configuration registers, front end,
// queue, two axis back ends and the result register. Depends on all files above.
//
// Maps coordinates between a display view and an image under a signed zoom, a
// view center and per-axis flip. Each request transfer carries an action:
// view to image, image to view, first visible pixel (lower bound) or view end
// (upper bound). One result transfer follows each request, in order. The block
// sustains one transfer per cycle while results are taken. The internal width W
// is max(COORD_BITS, FRAC_BITS+17)+8 (40 by default). A request passes through
// the front register, the queue, and per axis two pipelined divide/multiply
// units of ceil(W/4)+1 stages (mapping, pixel view position; four quotient bits
// per stage), the registers between them, a five-stage end-trimming unit and the
// result register. While the result is not taken the whole back end holds; the
// queue and the front register then take up to five more requests before the
// input stalls. Configuration writes are taken at any time and must be made
// while the block is idle.
module zoom_pan_flip_coordinate_mapper_unit #(
    parameter int COORD_BITS = zpf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = zpf_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    zpf_item_if.sink                         i_item,
    zpf_result_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [zpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_BITS-1:0]            i_cfg_data
);

    localparam int WIDE_W  = ((COORD_BITS > FRAC_BITS + 17) ? COORD_BITS : FRAC_BITS + 17) + 8;
    localparam int SW      = zpf_pkg::SPAN_W;
    localparam int PW      = zpf_pkg::PIX_W;
    localparam int AW      = zpf_pkg::ACT_W;
    localparam int ENTRY_W = AW + 2 * SW + 2 + 2 * WIDE_W;

    // ---- configuration registers ----
    logic signed [zpf_pkg::ZOOM_W-1:0] r_zoom;
    logic signed [COORD_BITS-1:0]      r_center_x;
    logic signed [COORD_BITS-1:0]      r_center_y;
    logic [SW-1:0]                     r_view_width;
    logic [SW-1:0]                     r_view_height;
    logic [1:0]                        r_flip;
    logic [PW-1:0]                     r_image_width;
    logic [PW-1:0]                     r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom         <= 6'sd1;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_view_width   <= '0;
            r_view_height  <= '0;
            r_flip         <= '0;
            r_image_width  <= '0;
            r_image_height <= '0;
        end else if (i_cfg_we) begin
            case (zpf_pkg::t_reg_index'(i_cfg_index))
                zpf_pkg::REG_ZOOM:         r_zoom         <= $signed(i_cfg_data[5:0]);
                zpf_pkg::REG_CENTER_X:     r_center_x     <= $signed(i_cfg_data);
                zpf_pkg::REG_CENTER_Y:     r_center_y     <= $signed(i_cfg_data);
                zpf_pkg::REG_VIEW_WIDTH:   r_view_width   <= i_cfg_data[SW-1:0];
                zpf_pkg::REG_VIEW_HEIGHT:  r_view_height  <= i_cfg_data[SW-1:0];
                zpf_pkg::REG_FLIP_MODE:    r_flip         <= i_cfg_data[1:0];
                zpf_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[PW-1:0];
                zpf_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // zero zoom acts as one
    zpf_pkg::t_zoom_ctl zoom_ctl;
    assign zoom_ctl = zpf_pkg::decode_zoom(r_zoom);

    // ---- front end and queue ----
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic [ENTRY_W-1:0] pop_data;
    logic               adv;

    zpf_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .WIDE_W     (WIDE_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_zoom_ctl    (zoom_ctl),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .i_view_width  (r_view_width),
        .i_view_height (r_view_height),
        .i_flip        (r_flip),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_data   (push_data)
    );

    zpf_queue #(.DATA_W(ENTRY_W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (adv),
        .o_pop_data   (pop_data)
    );

    // ---- back end: both axes advance together with the result register ----
    logic [AW-1:0]            u_action;
    logic [SW-1:0]            u_start_x;
    logic [SW-1:0]            u_start_y;
    logic                     u_mul_x;
    logic                     u_mul_y;
    logic signed [WIDE_W-1:0] u_d1_x;
    logic signed [WIDE_W-1:0] u_d1_y;

    assign {u_action, u_start_x, u_start_y, u_mul_x, u_mul_y, u_d1_x, u_d1_y} = pop_data;

    logic                         r_out_valid;
    assign adv = !r_out_valid || o_result.ready;

    logic                         x_valid;
    logic signed [COORD_BITS-1:0] x_result;
    logic [PW-1:0]                x_image;
    logic [SW-1:0]                x_screen;
    logic                         y_valid;
    logic signed [COORD_BITS-1:0] y_result;
    logic [PW-1:0]                y_image;
    logic [SW-1:0]                y_screen;

    zpf_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .WIDE_W     (WIDE_W)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (pop_valid),
        .i_action   (zpf_pkg::t_action'(u_action)),
        .i_start    (u_start_x),
        .i_d1       (u_d1_x),
        .i_mul      (u_mul_x),
        .i_zoom_ctl (zoom_ctl),
        .i_center   (r_center_x),
        .i_span     (r_view_width),
        .i_flip     (r_flip[0]),
        .i_limit    (r_image_width),
        .o_valid    (x_valid),
        .o_result   (x_result),
        .o_image    (x_image),
        .o_screen   (x_screen)
    );

    zpf_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .WIDE_W     (WIDE_W)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (pop_valid),
        .i_action   (zpf_pkg::t_action'(u_action)),
        .i_start    (u_start_y),
        .i_d1       (u_d1_y),
        .i_mul      (u_mul_y),
        .i_zoom_ctl (zoom_ctl),
        .i_center   (r_center_y),
        .i_span     (r_view_height),
        .i_flip     (r_flip[1]),
        .i_limit    (r_image_height),
        .o_valid    (y_valid),
        .o_result   (y_result),
        .o_image    (y_image),
        .o_screen   (y_screen)
    );

    // ---- result register ----
    logic signed [COORD_BITS-1:0] r_result_x;
    logic signed [COORD_BITS-1:0] r_result_y;
    logic [PW-1:0]                r_image_x;
    logic [PW-1:0]                r_image_y;
    logic [SW-1:0]                r_screen_x;
    logic [SW-1:0]                r_screen_y;

    // both axes run in lockstep, so one valid covers the pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= x_valid && y_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && x_valid) begin
            r_result_x <= x_result;
            r_result_y <= y_result;
            r_image_x  <= x_image;
            r_image_y  <= y_image;
            r_screen_x <= x_screen;
            r_screen_y <= y_screen;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.result_x = r_result_x;
    assign o_result.result_y = r_result_y;
    assign o_result.image_x  = r_image_x;
    assign o_result.image_y  = r_image_y;
    assign o_result.screen_x = r_screen_x;
    assign o_result.screen_y = r_screen_y;

endmodule

// ===== verif/testbench.sv =====
// Testbench for the zoom/pan/flip coordinate mapper: directed table, then random phases.
// Depends on zpf_pkg, zpf_item_if, zpf_result_if and zoom_pan_flip_coordinate_mapper_unit.
module testbench;

    localparam int  CB          = 32;
    localparam int  ONE_FX      = 256;
    localparam int  PW          = zpf_pkg::PIX_W;
    localparam int  SW          = zpf_pkg::SPAN_W;
    localparam int  DRAIN_WAIT  = 60;    // longer than a request takes through the pipeline
    localparam int  IDLE_LIMIT  = 5000;  // longest stall is the long hold, config waits are short
    localparam int  LONG_HOLD   = 300;
    localparam int  PHASES      = 12;
    localparam int  PHASE_ITEMS = 95;

    typedef struct packed {
        logic [CB-1:0] rx;
        logic [CB-1:0] ry;
        logic [PW-1:0] ix;
        logic [PW-1:0] iy;
        logic [SW-1:0] px;
        logic [SW-1:0] py;
    } t_mapped;

    typedef struct {
        zpf_pkg::t_action act;
        logic [CB-1:0]    cx;
        logic [CB-1:0]    cy;
        logic [SW-1:0]    sx;
        logic [SW-1:0]    sy;
        bit               typed;
        t_mapped          want;
    } t_req_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [zpf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CB-1:0] i_cfg_data = '0;

    zpf_item_if   item_if ();
    zpf_result_if result_if ();

    zoom_pan_flip_coordinate_mapper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the configuration registers as the block holds them
    logic signed [zpf_pkg::ZOOM_W-1:0] cfg_zoom = 6'sd1;
    longint cfg_cx = 0, cfg_cy = 0;
    longint cfg_vw = 0, cfg_vh = 0, cfg_iw = 0, cfg_ih = 0;
    logic [1:0] cfg_flip = 2'b00;

    t_mapped pending_maps[$];
    int      err_cnt = 0;
    int      idle_cycles = 0;
    bit      hold_request = 1'b0;
    int      hold_left = 0;
    int      stall_mode = 0;
    int      stall_timer = 0;

    initial begin
        item_if.valid   = 1'b0;
        item_if.action  = zpf_pkg::ACT_TO_IMAGE;
        item_if.coord_x = '0;
        item_if.coord_y = '0;
        item_if.start_x = '0;
        item_if.start_y = '0;
        result_if.ready = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint zoom_factor();
        longint z;
        z = longint'(cfg_zoom);
        return (z == 0) ? 1 : z;
    endfunction

    function automatic longint view_to_image(longint c, longint span, longint ctr, bit flip);
        longint z, d;
        z = zoom_factor();
        d = c - (span >>> 1) * ONE_FX;
        d = (z > 0) ? d / z : d * (-z);
        return flip ? ctr - d : ctr + d;
    endfunction

    function automatic longint image_to_view(longint c, longint span, longint ctr, bit flip);
        longint z, d;
        z = zoom_factor();
        d = flip ? ctr - c : c - ctr;
        d = (z > 0) ? d * z : d / (-z);
        return d + (span >>> 1) * ONE_FX;
    endfunction

    function automatic longint clip_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Whole image pixel: values at or below zero give 0, fractions round up when asked, capped at the limit
    function automatic longint whole_pixel(longint p, bit up, longint limit);
        longint i;
        if (p <= 0) return 0;
        i = p / ONE_FX;
        if ((p % ONE_FX) != 0 && up) i++;
        return (i > limit) ? limit : i;
    endfunction

    function automatic longint view_pos(longint img, longint span, longint ctr, bit flip);
        longint v, s;
        v = image_to_view(img * ONE_FX, span, ctr, flip) + ONE_FX / 2;
        if (v <= 0) return 0;
        s = v / ONE_FX;
        return (s > span) ? span : s;
    endfunction

    // Snap the end to whole zoomed pixels; a start beyond the end grows it
    function automatic longint snap_end(longint e, longint s);
        longint z;
        z = zoom_factor();
        if (z > 1) e -= (e - s) % z;
        if (e > zpf_pkg::SCREEN_MAX) e = zpf_pkg::SCREEN_MAX;
        if (e < 0) e = 0;
        return e;
    endfunction

    function automatic t_mapped map_request(zpf_pkg::t_action act, logic signed [CB-1:0] cx,
                                            logic signed [CB-1:0] cy,
                                            logic [SW-1:0] sx, logic [SW-1:0] sy);
        t_mapped m;
        longint ex, ey, ix, iy;
        bit fx, fy;
        fx = cfg_flip[0];
        fy = cfg_flip[1];
        m = '0;
        case (act)
            zpf_pkg::ACT_TO_IMAGE: begin
                m.rx = CB'(clip_coord(view_to_image(longint'(cx), cfg_vw, cfg_cx, fx)));
                m.ry = CB'(clip_coord(view_to_image(longint'(cy), cfg_vh, cfg_cy, fy)));
            end
            zpf_pkg::ACT_TO_VIEW: begin
                m.rx = CB'(clip_coord(image_to_view(longint'(cx), cfg_vw, cfg_cx, fx)));
                m.ry = CB'(clip_coord(image_to_view(longint'(cy), cfg_vh, cfg_cy, fy)));
            end
            zpf_pkg::ACT_LOWER: begin
                ix = whole_pixel(view_to_image(0, cfg_vw, cfg_cx, fx), !fx, cfg_iw);
                iy = whole_pixel(view_to_image(0, cfg_vh, cfg_cy, fy), !fy, cfg_ih);
                m.ix = PW'(ix);
                m.iy = PW'(iy);
                m.px = SW'(view_pos(ix, cfg_vw, cfg_cx, fx));
                m.py = SW'(view_pos(iy, cfg_vh, cfg_cy, fy));
            end
            default: begin
                ex = whole_pixel(view_to_image(cfg_vw * ONE_FX, cfg_vw, cfg_cx, fx), fx, cfg_iw);
                ey = whole_pixel(view_to_image(cfg_vh * ONE_FX, cfg_vh, cfg_cy, fy), fy, cfg_ih);
                m.px = SW'(snap_end(view_pos(ex, cfg_vw, cfg_cx, fx), longint'(sx)));
                m.py = SW'(snap_end(view_pos(ey, cfg_vh, cfg_cy, fy), longint'(sy)));
            end
        endcase
        return m;
    endfunction

    // ---------------- configuration ----------------
    task automatic write_reg(zpf_pkg::t_reg_index idx, logic [CB-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            zpf_pkg::REG_ZOOM:        cfg_zoom = val[zpf_pkg::ZOOM_W-1:0];
            zpf_pkg::REG_CENTER_X:    cfg_cx = longint'(signed'(val));
            zpf_pkg::REG_CENTER_Y:    cfg_cy = longint'(signed'(val));
            zpf_pkg::REG_VIEW_WIDTH:  cfg_vw = longint'(val[SW-1:0]);
            zpf_pkg::REG_VIEW_HEIGHT: cfg_vh = longint'(val[SW-1:0]);
            zpf_pkg::REG_FLIP_MODE:   cfg_flip = val[1:0];
            zpf_pkg::REG_IMAGE_WIDTH: cfg_iw = longint'(val[PW-1:0]);
            default:                  cfg_ih = longint'(val[PW-1:0]);
        endcase
    endtask

    task automatic wait_drained();
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // ---------------- request side ----------------
    int burst_left = 0;

    // One request transfer; valid stays high across a burst
    task automatic send_req(zpf_pkg::t_action act, logic [CB-1:0] cx, logic [CB-1:0] cy,
                            logic [SW-1:0] sx, logic [SW-1:0] sy,
                            bit typed, t_mapped want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_if.valid   <= 1'b1;
        item_if.action  <= act;
        item_if.coord_x <= cx;
        item_if.coord_y <= cy;
        item_if.start_x <= sx;
        item_if.start_y <= sy;
        do @(posedge i_clk); while (!item_if.ready);
        pending_maps.push_back(typed ? want : map_request(act, cx, cy, sx, sy));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [CB-1:0] pick_coord(longint span);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return CB'(longint'($urandom_range(0, span * 2 * ONE_FX + 512)) - 256);
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_center(longint limit);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return CB'(longint'($urandom_range(0, limit * ONE_FX + 1024)) - 512);
        endcase
    endfunction

    // ---------------- stimulus ----------------
    t_req_row dir_rows[$];

    task automatic build_directed();
        t_req_row r;
        // Reset settings: unit zoom, zero center and spans, so mapping is identity
        r = '{zpf_pkg::ACT_TO_IMAGE, 32'd256, 32'hFFFF_FF00, 13'd0, 13'd0, 1'b1,
              '{32'd256, 32'hFFFF_FF00, 16'd0, 16'd0, 13'd0, 13'd0}};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_TO_IMAGE, 32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd0, 1'b1,
              '{32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0, 13'd0, 13'd0}};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_TO_VIEW, 32'h7FFF_FFFF, 32'h8000_0000, 13'd0, 13'd0, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 13'd0, 13'd0}};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_TO_VIEW, 32'd0, 32'd1, 13'd0, 13'd0, 1'b1,
              '{32'd0, 32'd1, 16'd0, 16'd0, 13'd0, 13'd0}};
        dir_rows.push_back(r);
        // Lower and upper bound with empty view and image: everything clamps to 0
        r = '{zpf_pkg::ACT_LOWER, 32'h1234_5678, 32'hFFFF_FFFF, 13'd0, 13'd0, 1'b1, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_UPPER, 32'd0, 32'd0, 13'h1FFF, 13'h1FFF, 1'b1, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_UPPER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0, 13'd4096, 1'b1, '0};
        dir_rows.push_back(r);
    endtask

    // Rows checked against the predictor under the extreme settings
    task automatic build_extreme_rows();
        t_req_row r;
        r = '{zpf_pkg::ACT_TO_IMAGE, 32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd0, 1'b0, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_TO_VIEW, 32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd0, 1'b0, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_TO_VIEW, 32'h7FFF_FFFF, 32'h8000_0000, 13'd0, 13'd0, 1'b0, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_LOWER, 32'd0, 32'd0, 13'd0, 13'd0, 1'b0, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_UPPER, 32'd0, 32'd0, 13'd0, 13'd0, 1'b0, '0};
        dir_rows.push_back(r);
        // start past the end: remainder goes non-positive and the end grows
        r = '{zpf_pkg::ACT_UPPER, 32'd0, 32'd0, 13'h1FFF, 13'd4096, 1'b0, '0};
        dir_rows.push_back(r);
        r = '{zpf_pkg::ACT_UPPER, 32'd0, 32'd0, 13'd7, 13'd3, 1'b0, '0};
        dir_rows.push_back(r);
    endtask

    task automatic walk_rows(int first, int last);
        for (int i = first; i < last; i++)
            send_req(dir_rows[i].act, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].sx,
                     dir_rows[i].sy, dir_rows[i].typed, dir_rows[i].want);
        stop_sending();
        wait_drained();
    endtask

    // Settings for one random phase; the first few pin the extremes of each register
    task automatic set_phase(int ph);
        logic [CB-1:0] z;
        longint vw, vh, iw, ih;
        case (ph)
            0: z = 32'd16;
            1: z = 32'hFFFF_FFF0;          // -16
            2: z = 32'd0;
            3: z = 32'h20;                 // -32 in six bits
            4: z = 32'd31;
            default: z = CB'($urandom_range(0, 33) - 16);
        endcase
        vw = (ph == 0) ? 4096 : (ph == 1) ? 0 : (ph == 4) ? 8191 : $urandom_range(0, 300);
        vh = (ph == 0) ? 4096 : (ph == 1) ? 0 : (ph == 4) ? 8191 : $urandom_range(0, 300);
        iw = (ph == 0) ? 65535 : (ph == 1) ? 0 : $urandom_range(0, 1000);
        ih = (ph == 0) ? 65535 : (ph == 1) ? 0 : $urandom_range(0, 1000);
        write_reg(zpf_pkg::REG_ZOOM, z);
        write_reg(zpf_pkg::REG_VIEW_WIDTH, CB'(vw));
        write_reg(zpf_pkg::REG_VIEW_HEIGHT, CB'(vh));
        write_reg(zpf_pkg::REG_IMAGE_WIDTH, CB'(iw));
        write_reg(zpf_pkg::REG_IMAGE_HEIGHT, CB'(ih));
        write_reg(zpf_pkg::REG_FLIP_MODE, CB'(ph % 4));
        write_reg(zpf_pkg::REG_CENTER_X, (ph == 0) ? 32'h7FFF_FFFF
                                        : (ph == 1) ? 32'h8000_0000 : pick_center(iw));
        write_reg(zpf_pkg::REG_CENTER_Y, (ph == 0) ? 32'h8000_0000
                                        : (ph == 1) ? 32'h7FFF_FFFF : pick_center(ih));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        build_directed();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        walk_rows(0, dir_rows.size());
        build_extreme_rows();
        set_phase(0);
        walk_rows(7, dir_rows.size());

        for (int ph = 0; ph < PHASES; ph++) begin
            set_phase(ph);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long hold-off on the result side while requests keep coming
                if (ph == 3 && n == 10) hold_request = 1'b1;
                // and one pause on the request side until everything is back
                if (ph == 5 && n == 50) begin
                    stop_sending();
                    while (pending_maps.size() != 0) @(posedge i_clk);
                end
                send_req(zpf_pkg::t_action'($urandom_range(0, 3)), pick_coord(cfg_vw),
                         pick_coord(cfg_vh), SW'($urandom), SW'($urandom),
                         1'b0, '0);
            end
            stop_sending();
            wait_drained();
        end

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ---------------- result side ----------------
    // Ready follows a changing stall pattern; a long hold is counted here
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = LONG_HOLD;
        end
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(16, 96);
        end
        stall_timer--;
        if (hold_left > 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= ($urandom_range(0, 3) != 0);
                2:       result_if.ready <= ($urandom_range(0, 2) == 0);
                default: result_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_mapped want, got;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = '{result_if.result_x, result_if.result_y, result_if.image_x,
                    result_if.image_y, result_if.screen_x, result_if.screen_y};
            if (pending_maps.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result transfer, got %h", $realtime, got);
            end else begin
                want = pending_maps.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    $display("%0t: mismatch rx exp %h act %h, ry exp %h act %h",
                             $realtime, want.rx, got.rx, want.ry, got.ry);
                    $display("%0t:   ix exp %h act %h, iy exp %h act %h", $realtime,
                             want.ix, got.ix, want.iy, got.iy);
                    $display("%0t:   px exp %h act %h, py exp %h act %h", $realtime,
                             want.px, got.px, want.py, got.py);
                end
            end
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
hw/rtl/zpf_pkg.sv
hw/rtl/zpf_if.sv
hw/rtl/zpf_front.sv
hw/rtl/zpf_queue.sv
hw/rtl/zpf_scale.sv
hw/rtl/zpf_axis.sv
hw/rtl/zoom_pan_flip_coordinate_mapper_unit.sv
verif/testbench.sv
